### rtl/core/lsdc_pkg.sv
// shared types and codes for the limit switch door controller
package lsdc_pkg;

    localparam int TICK_W = 17;

    // action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_OPEN   = 3'd1;
    localparam logic [2:0] ACT_CLOSE  = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_AUTO   = 3'd4;
    localparam logic [2:0] ACT_SAMPLE = 3'd5;

    // door states
    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_OPEN    = 3'd1;
    localparam logic [2:0] ST_CLOSED  = 3'd2;
    localparam logic [2:0] ST_OPENING = 3'd3;
    localparam logic [2:0] ST_CLOSING = 3'd4;
    localparam logic [2:0] ST_HALTED  = 3'd5;

    // led modes
    localparam logic [1:0] LED_OFF  = 2'd0;
    localparam logic [1:0] LED_ON   = 2'd1;
    localparam logic [1:0] LED_SLOW = 2'd2;
    localparam logic [1:0] LED_FAST = 2'd3;

    // motor drive
    localparam logic [1:0] MOT_STOP = 2'd0;
    localparam logic [1:0] MOT_FWD  = 2'd1;
    localparam logic [1:0] MOT_BACK = 2'd2;

    localparam logic [TICK_W-1:0] TICK_MAX      = 17'h1FFFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 17'd120000;

    typedef struct packed {
        logic [2:0] action;
        logic       manual_override;
        logic       closed_switch;
        logic       open_switch;
    } t_item;

    typedef struct packed {
        logic [2:0]        door_mode;
        logic              manual_flag;
        logic [TICK_W-1:0] run_ticks;
        logic [1:0]        red_mode;
        logic [1:0]        green_mode;
        logic [1:0]        motor_mode;
    } t_state;

    typedef struct packed {
        logic [2:0] door_state;
        logic [1:0] motor_drive;
        logic [1:0] red_led_mode;
        logic [1:0] green_led_mode;
        logic       halt_event;
        logic       open_or_opening;
        logic       closed_or_closing;
    } t_result;

endpackage

### rtl/core/lsdc_in_stage.sv
// input register holding one item ahead of the update logic
module lsdc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lsdc_pkg::t_item i_item,
    output logic           o_valid,
    output lsdc_pkg::t_item o_item,
    input  logic           i_take
);

    logic            r_valid;
    lsdc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/core/lsdc_step.sv
// next door state and result for one item
module lsdc_step (
    input  lsdc_pkg::t_state               i_state,
    input  lsdc_pkg::t_item                i_item,
    input  logic [lsdc_pkg::TICK_W-1:0]    i_timeout,
    output lsdc_pkg::t_state               o_state,
    output lsdc_pkg::t_result              o_result
);

    lsdc_pkg::t_state              s;
    logic                          halt;
    logic [lsdc_pkg::TICK_W-1:0]   ticks_inc;
    logic                          end_pressed;
    logic [2:0]                    end_state;
    logic [1:0]                    lit_mode;

    always_comb begin
        ticks_inc = (i_state.run_ticks == lsdc_pkg::TICK_MAX) ? i_state.run_ticks
                                                              : i_state.run_ticks + 1'b1;
        end_pressed = (i_state.door_mode == lsdc_pkg::ST_OPENING) ? i_item.open_switch
                                                                   : i_item.closed_switch;
        end_state   = (i_state.door_mode == lsdc_pkg::ST_OPENING) ? lsdc_pkg::ST_OPEN
                                                                   : lsdc_pkg::ST_CLOSED;
        lit_mode    = i_state.manual_flag ? lsdc_pkg::LED_FAST : lsdc_pkg::LED_ON;
        s    = i_state;
        halt = 1'b0;

        unique case (i_item.action)
            lsdc_pkg::ACT_TICK: begin
                if (i_state.door_mode == lsdc_pkg::ST_OPENING ||
                    i_state.door_mode == lsdc_pkg::ST_CLOSING) begin
                    if (end_pressed) begin
                        s.door_mode  = end_state;
                        s.motor_mode = lsdc_pkg::MOT_STOP;
                        // led refresh at the end reached
                        if (end_state == lsdc_pkg::ST_OPEN) begin
                            s.green_mode = lit_mode;
                        end else begin
                            s.red_mode = lit_mode;
                        end
                    end else begin
                        s.run_ticks = ticks_inc;
                        if (ticks_inc > i_timeout) begin
                            s.motor_mode = lsdc_pkg::MOT_STOP;
                            s.door_mode  = lsdc_pkg::ST_HALTED;
                            halt         = 1'b1;
                        end
                    end
                end
            end
            lsdc_pkg::ACT_OPEN: begin
                if (i_state.door_mode != lsdc_pkg::ST_OPEN &&
                    i_state.door_mode != lsdc_pkg::ST_OPENING) begin
                    s.door_mode   = lsdc_pkg::ST_OPENING;
                    s.motor_mode  = lsdc_pkg::MOT_FWD;
                    s.run_ticks   = '0;
                    s.red_mode    = lsdc_pkg::LED_OFF;
                    s.green_mode  = lsdc_pkg::LED_SLOW;
                    s.manual_flag = i_item.manual_override;
                end
            end
            lsdc_pkg::ACT_CLOSE: begin
                if (i_state.door_mode != lsdc_pkg::ST_CLOSED &&
                    i_state.door_mode != lsdc_pkg::ST_CLOSING) begin
                    s.door_mode   = lsdc_pkg::ST_CLOSING;
                    s.motor_mode  = lsdc_pkg::MOT_BACK;
                    s.run_ticks   = '0;
                    s.green_mode  = lsdc_pkg::LED_OFF;
                    s.red_mode    = lsdc_pkg::LED_SLOW;
                    s.manual_flag = i_item.manual_override;
                end
            end
            lsdc_pkg::ACT_STOP: begin
                s.motor_mode = lsdc_pkg::MOT_STOP;
                s.red_mode   = lsdc_pkg::LED_OFF;
                s.green_mode = lsdc_pkg::LED_OFF;
            end
            lsdc_pkg::ACT_AUTO: begin
                // manual flag is cleared first, so a refresh shows steady on
                s.manual_flag = 1'b0;
                if (i_state.door_mode == lsdc_pkg::ST_OPEN) begin
                    s.green_mode = lsdc_pkg::LED_ON;
                end else if (i_state.door_mode == lsdc_pkg::ST_CLOSED) begin
                    s.red_mode = lsdc_pkg::LED_ON;
                end
            end
            lsdc_pkg::ACT_SAMPLE: begin
                if (i_item.open_switch) begin
                    s.door_mode = lsdc_pkg::ST_OPEN;
                end else if (i_item.closed_switch) begin
                    s.door_mode = lsdc_pkg::ST_CLOSED;
                end else begin
                    s.door_mode = lsdc_pkg::ST_UNKNOWN;
                end
            end
            default: begin
            end
        endcase
    end

    // lit_mode is only meaningful on the end switch path
    assign o_state = s;

    always_comb begin
        o_result.door_state        = s.door_mode;
        o_result.motor_drive       = s.motor_mode;
        o_result.red_led_mode      = s.red_mode;
        o_result.green_led_mode    = s.green_mode;
        o_result.halt_event        = halt;
        o_result.open_or_opening   = (s.door_mode == lsdc_pkg::ST_OPEN) ||
                                     (s.door_mode == lsdc_pkg::ST_OPENING);
        o_result.closed_or_closing = (s.door_mode == lsdc_pkg::ST_CLOSED) ||
                                     (s.door_mode == lsdc_pkg::ST_CLOSING);
    end

endmodule

### rtl/core/limit_switch_door_controller_core.sv
// top level of the limit switch door controller
//
// usage
//  - input channel (i_in_valid / o_in_ready) carries one item: an action code
//    (tick, open, close, stop, auto mode on, sample switches) with the manual
//    flag and both limit switch levels
//  - output channel (o_out_valid / i_out_ready) returns one item per input
//    item: door state, motor drive, led modes, halt pulse and two summary bits
//  - config channel (i_cfg_valid / o_cfg_ready) writes the jam timeout in
//    ticks; always ready, write it only while the block is idle
//  - an accepted item sits in the input register, then the update logic
//    writes the door state and the result register at the same edge
//  - throughput is one item per cycle while the receiver takes results; the
//    next item sees the state left by the previous one because the state
//    registers update as the result loads
//  - a stalled receiver holds the result register; the input register then
//    holds its item and o_in_ready falls only once both are full
//  - reset (synchronous, active low) empties both registers, sets the door
//    unknown, motor stopped, leds off, tick count zero, timeout 120000
module limit_switch_door_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic        i_manual_override,
    input  logic        i_closed_switch,
    input  logic        i_open_switch,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_door_state,
    output logic [1:0]  o_motor_drive,
    output logic [1:0]  o_red_led_mode,
    output logic [1:0]  o_green_led_mode,
    output logic        o_halt_event,
    output logic        o_open_or_opening,
    output logic        o_closed_or_closing,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    lsdc_pkg::t_item                 in_item;
    lsdc_pkg::t_item                 stage_item;
    logic                            stage_valid;
    logic                            take;

    lsdc_pkg::t_state                r_state;
    lsdc_pkg::t_state                n_state;
    lsdc_pkg::t_result               r_out;
    lsdc_pkg::t_result               n_out;
    logic                            r_out_valid;
    logic [lsdc_pkg::TICK_W-1:0]     r_timeout;

    assign in_item.action          = i_action;
    assign in_item.manual_override = i_manual_override;
    assign in_item.closed_switch   = i_closed_switch;
    assign in_item.open_switch     = i_open_switch;

    // the staged item moves on when the result register is free or draining
    assign take = stage_valid && (!r_out_valid || i_out_ready);

    lsdc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (take)
    );

    lsdc_step u_step (
        .i_state   (r_state),
        .i_item    (stage_item),
        .i_timeout (r_timeout),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= lsdc_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    // door state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.door_mode   <= lsdc_pkg::ST_UNKNOWN;
            r_state.manual_flag <= 1'b0;
            r_state.run_ticks   <= '0;
            r_state.red_mode    <= lsdc_pkg::LED_OFF;
            r_state.green_mode  <= lsdc_pkg::LED_OFF;
            r_state.motor_mode  <= lsdc_pkg::MOT_STOP;
        end else if (take) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_door_state        = r_out.door_state;
    assign o_motor_drive       = r_out.motor_drive;
    assign o_red_led_mode      = r_out.red_led_mode;
    assign o_green_led_mode    = r_out.green_led_mode;
    assign o_halt_event        = r_out.halt_event;
    assign o_open_or_opening   = r_out.open_or_opening;
    assign o_closed_or_closing = r_out.closed_or_closing;

endmodule

### tb/sv/tb_limit_switch_door_controller_core.sv
// self-checking testbench for the limit switch door controller core
module tb_limit_switch_door_controller_core;

    // run limit in clock cycles
    localparam int CYCLE_LIMIT = 1_000_000;
    // long receiver hold-off used to fill the block and stall its input
    localparam int HOLD_CYCLES = 300;
    // ticks pushed in the top of range run
    localparam int SAT_TICKS   = 24;

    logic        i_clk;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_action            = lsdc_pkg::ACT_TICK;
    logic        i_manual_override   = 1'b0;
    logic        i_closed_switch     = 1'b0;
    logic        i_open_switch       = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready         = 1'b0;
    logic [2:0]  o_door_state;
    logic [1:0]  o_motor_drive;
    logic [1:0]  o_red_led_mode;
    logic [1:0]  o_green_led_mode;
    logic        o_halt_event;
    logic        o_open_or_opening;
    logic        o_closed_or_closing;
    logic        i_cfg_valid         = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data          = '0;

    limit_switch_door_controller_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_manual_override   (i_manual_override),
        .i_closed_switch     (i_closed_switch),
        .i_open_switch       (i_open_switch),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_door_state        (o_door_state),
        .o_motor_drive       (o_motor_drive),
        .o_red_led_mode      (o_red_led_mode),
        .o_green_led_mode    (o_green_led_mode),
        .o_halt_event        (o_halt_event),
        .o_open_or_opening   (o_open_or_opening),
        .o_closed_or_closing (o_closed_or_closing),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    // door commands waiting to be sent, and door reports still owed by the block
    lsdc_pkg::t_item   door_cmds[$];
    lsdc_pkg::t_result expected_door[$];

    // handshake bookkeeping, all counters move on one edge only
    int cmds_offered = 0;   // items raised by the sender (falling edge)
    int cmds_taken   = 0;   // items accepted by the block (rising edge)
    int reports_seen = 0;   // results accepted from the block (rising edge)
    int mismatches   = 0;
    int cycle_cnt    = 0;

    // idling controls set by the stimulus per phase
    logic src_idle_en = 1'b1;
    logic snk_idle_en = 1'b1;
    int   src_gap     = 0;
    int   stall_left  = 0;
    int   hold_asked  = 0;
    int   hold_done   = 0;
    int   hold_left   = 0;

    // predictor copy of the door state and the jam limit
    logic [2:0]                  door_st   = lsdc_pkg::ST_UNKNOWN;
    logic                        manual_st = 1'b0;
    logic [lsdc_pkg::TICK_W-1:0] ticks_st  = '0;
    logic [1:0]                  red_st    = lsdc_pkg::LED_OFF;
    logic [1:0]                  green_st  = lsdc_pkg::LED_OFF;
    logic [1:0]                  motor_st  = lsdc_pkg::MOT_STOP;
    logic [lsdc_pkg::TICK_W-1:0] jam_limit = lsdc_pkg::TIMEOUT_RESET;

    lsdc_pkg::t_item   sent_cmd;
    lsdc_pkg::t_item   seen_cmd;
    lsdc_pkg::t_result want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // door predictor
    // ------------------------------------------------------------------

    // lit end led: steady in auto mode, fast blink after a manual command
    function automatic void leds_refresh();
        if (door_st == lsdc_pkg::ST_OPEN)
            green_st = manual_st ? lsdc_pkg::LED_FAST : lsdc_pkg::LED_ON;
        else if (door_st == lsdc_pkg::ST_CLOSED)
            red_st = manual_st ? lsdc_pkg::LED_FAST : lsdc_pkg::LED_ON;
    endfunction

    // one tick of a moving door; returns 1 when the door jams
    function automatic logic tick_motion(input logic end_hit, input logic [2:0] end_state);
        if (end_hit) begin
            door_st  = end_state;
            motor_st = lsdc_pkg::MOT_STOP;
            leds_refresh();
            return 1'b0;
        end
        // saturating run count
        if (ticks_st != lsdc_pkg::TICK_MAX)
            ticks_st = ticks_st + 1'b1;
        if (ticks_st > jam_limit) begin
            motor_st = lsdc_pkg::MOT_STOP;
            door_st  = lsdc_pkg::ST_HALTED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic lsdc_pkg::t_result door_next(input lsdc_pkg::t_item cmd);
        lsdc_pkg::t_result r;
        logic              jam;
        jam = 1'b0;
        case (cmd.action)
            lsdc_pkg::ACT_TICK: begin
                // switches only matter while the door is on the move
                if (door_st == lsdc_pkg::ST_OPENING)
                    jam = tick_motion(cmd.open_switch, lsdc_pkg::ST_OPEN);
                else if (door_st == lsdc_pkg::ST_CLOSING)
                    jam = tick_motion(cmd.closed_switch, lsdc_pkg::ST_CLOSED);
            end
            lsdc_pkg::ACT_OPEN: begin
                if (door_st != lsdc_pkg::ST_OPEN && door_st != lsdc_pkg::ST_OPENING) begin
                    door_st   = lsdc_pkg::ST_OPENING;
                    motor_st  = lsdc_pkg::MOT_FWD;
                    ticks_st  = '0;
                    red_st    = lsdc_pkg::LED_OFF;
                    green_st  = lsdc_pkg::LED_SLOW;
                    manual_st = cmd.manual_override;
                end
            end
            lsdc_pkg::ACT_CLOSE: begin
                if (door_st != lsdc_pkg::ST_CLOSED && door_st != lsdc_pkg::ST_CLOSING) begin
                    door_st   = lsdc_pkg::ST_CLOSING;
                    motor_st  = lsdc_pkg::MOT_BACK;
                    ticks_st  = '0;
                    green_st  = lsdc_pkg::LED_OFF;
                    red_st    = lsdc_pkg::LED_SLOW;
                    manual_st = cmd.manual_override;
                end
            end
            lsdc_pkg::ACT_STOP: begin
                // door state kept, so a moving door is still timed
                motor_st = lsdc_pkg::MOT_STOP;
                red_st   = lsdc_pkg::LED_OFF;
                green_st = lsdc_pkg::LED_OFF;
            end
            lsdc_pkg::ACT_AUTO: begin
                manual_st = 1'b0;
                leds_refresh();
            end
            lsdc_pkg::ACT_SAMPLE: begin
                // open switch wins when both are pressed
                door_st = lsdc_pkg::ST_UNKNOWN;
                if (cmd.closed_switch)
                    door_st = lsdc_pkg::ST_CLOSED;
                if (cmd.open_switch)
                    door_st = lsdc_pkg::ST_OPEN;
            end
            default: ;
        endcase
        r.door_state        = door_st;
        r.motor_drive       = motor_st;
        r.red_led_mode      = red_st;
        r.green_led_mode    = green_st;
        r.halt_event        = jam;
        r.open_or_opening   = (door_st == lsdc_pkg::ST_OPEN ||
                               door_st == lsdc_pkg::ST_OPENING);
        r.closed_or_closing = (door_st == lsdc_pkg::ST_CLOSED ||
                               door_st == lsdc_pkg::ST_CLOSING);
        return r;
    endfunction

    function automatic void check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // sender: one item at a time from the command queue, payload held until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && cmds_taken != cmds_offered) begin
                // item still on offer
            end else if (src_gap > 0) begin
                src_gap    <= src_gap - 1;
                i_in_valid <= 1'b0;
            end else if (door_cmds.size() > 0) begin
                sent_cmd          = door_cmds.pop_front();
                i_action          <= sent_cmd.action;
                i_manual_override <= sent_cmd.manual_override;
                i_closed_switch   <= sent_cmd.closed_switch;
                i_open_switch     <= sent_cmd.open_switch;
                i_in_valid        <= 1'b1;
                cmds_offered      <= cmds_offered + 1;
                src_gap           <= src_idle_en ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_done   <= hold_done + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(3) == 0) begin
            stall_left  <= pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on every accepted item, check every accepted result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                seen_cmd.action          = i_action;
                seen_cmd.manual_override = i_manual_override;
                seen_cmd.closed_switch   = i_closed_switch;
                seen_cmd.open_switch     = i_open_switch;
                expected_door.push_back(door_next(seen_cmd));
                cmds_taken <= cmds_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                reports_seen <= reports_seen + 1;
                if (expected_door.size() == 0) begin
                    $display("%0t: result with none expected, door_state %0d",
                             $time, o_door_state);
                    mismatches++;
                end else begin
                    want = expected_door.pop_front();
                    check_field("door_state", int'(want.door_state), int'(o_door_state));
                    check_field("motor_drive", int'(want.motor_drive),
                                int'(o_motor_drive));
                    check_field("red_led_mode", int'(want.red_led_mode),
                                int'(o_red_led_mode));
                    check_field("green_led_mode", int'(want.green_led_mode),
                                int'(o_green_led_mode));
                    check_field("halt_event", int'(want.halt_event), int'(o_halt_event));
                    check_field("open_or_opening", int'(want.open_or_opening),
                                int'(o_open_or_opening));
                    check_field("closed_or_closing", int'(want.closed_or_closing),
                                int'(o_closed_or_closing));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic [2:0] act, input logic man, input logic cs,
                             input logic os);
        lsdc_pkg::t_item it;
        it.action          = act;
        it.manual_override = man;
        it.closed_switch   = cs;
        it.open_switch     = os;
        door_cmds.push_back(it);
    endtask

    // all commands sent and every report back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (!(door_cmds.size() == 0 && !i_in_valid && reports_seen == cmds_taken));
    endtask

    task automatic write_jam_limit(input logic [16:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        jam_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain, reprogram the jam limit and pick the idling for the next phase
    task automatic start_phase(input logic [16:0] value, input logic src_en,
                               input logic snk_en);
        wait_drained();
        write_jam_limit(value);
        src_idle_en = src_en;
        snk_idle_en = snk_en;
    endtask

    // mostly complete moves (command, a run of ticks, often the end switch),
    // with stray commands dropped in and some pure noise
    task automatic random_traffic(input int n);
        int   made;
        int   run_len;
        int   k;
        logic open_dir;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 75) begin
                open_dir = 1'($urandom_range(1));
                push_item(open_dir ? lsdc_pkg::ACT_OPEN : lsdc_pkg::ACT_CLOSE,
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                run_len = $urandom_range(0, (jam_limit < 40) ? jam_limit + 3 : 40);
                for (k = 0; k < run_len; k++) begin
                    if ($urandom_range(99) < 6)
                        push_item(3'($urandom_range(1, 7)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                    else if (open_dir)
                        push_item(lsdc_pkg::ACT_TICK, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'b0);
                    else
                        push_item(lsdc_pkg::ACT_TICK, 1'($urandom_range(1)), 1'b0,
                                  1'($urandom_range(1)));
                end
                if ($urandom_range(99) < 60) begin
                    if (open_dir)
                        push_item(lsdc_pkg::ACT_TICK, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'b1);
                    else
                        push_item(lsdc_pkg::ACT_TICK, 1'($urandom_range(1)), 1'b1,
                                  1'($urandom_range(1)));
                end
                if ($urandom_range(99) < 25)
                    push_item($urandom_range(1) ? lsdc_pkg::ACT_AUTO : lsdc_pkg::ACT_STOP,
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                made += run_len + 2;
            end else begin
                push_item(3'($urandom_range(7)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    initial begin
        int k;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset jam limit
        push_item(3'd6, 1'b1, 1'b1, 1'b1);                    // undefined codes change nothing
        push_item(3'd7, 1'b0, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1);      // tick on an unknown door
        push_item(lsdc_pkg::ACT_SAMPLE, 1'b0, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_SAMPLE, 1'b0, 1'b1, 1'b0);    // closed
        push_item(lsdc_pkg::ACT_SAMPLE, 1'b1, 1'b1, 1'b1);    // both pressed, open wins
        push_item(lsdc_pkg::ACT_AUTO, 1'b1, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_OPEN, 1'b1, 1'b0, 1'b0);      // already open, ignored
        push_item(lsdc_pkg::ACT_CLOSE, 1'b1, 1'b0, 1'b1);     // manual close
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b0, 1'b1);      // wrong switch only
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b1, 1'b0);      // closed, fast blink
        push_item(lsdc_pkg::ACT_AUTO, 1'b0, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_STOP, 1'b1, 1'b1, 1'b1);
        push_item(lsdc_pkg::ACT_OPEN, 1'b0, 1'b1, 1'b1);
        push_item(lsdc_pkg::ACT_STOP, 1'b0, 1'b0, 1'b0);      // stopped but still opening
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b0, 1'b1);      // end switch after a stop
        push_item(lsdc_pkg::ACT_CLOSE, 1'b0, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_CLOSE, 1'b1, 1'b1, 1'b1);     // already closing, ignored
        push_item(lsdc_pkg::ACT_SAMPLE, 1'b0, 1'b0, 1'b1);    // open while the motor runs

        // jam limit below range: the first tick without the switch halts
        start_phase(17'd0, 1'b1, 1'b1);
        push_item(lsdc_pkg::ACT_CLOSE, 1'b0, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1);      // halted door ignores ticks
        push_item(lsdc_pkg::ACT_OPEN, 1'b1, 1'b0, 1'b0);

        // lowest limit: the second tick halts
        start_phase(17'd1, 1'b1, 1'b1);
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b1, 1'b0);
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b1, 1'b0);

        // top of range: the door keeps running until its end switch
        start_phase(lsdc_pkg::TICK_MAX, 1'b0, 1'b0);
        push_item(lsdc_pkg::ACT_OPEN, 1'b0, 1'b0, 1'b0);
        for (k = 0; k < SAT_TICKS; k++)
            push_item(lsdc_pkg::ACT_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        push_item(lsdc_pkg::ACT_TICK, 1'b0, 1'b0, 1'b1);

        // random phases; the first one opens with a long receiver hold-off
        // while the sender keeps offering, so the block fills and stalls
        start_phase(17'($urandom_range(2, 8)), 1'b0, 1'b1);
        random_traffic(160);
        hold_asked++;

        // no idling at all
        start_phase(17'd1, 1'b0, 1'b0);
        random_traffic(160);

        // sender pauses mid-phase until every report is back
        start_phase(17'($urandom_range(9, 40)), 1'b1, 1'b0);
        random_traffic(80);
        wait_drained();
        random_traffic(80);

        start_phase(lsdc_pkg::TICK_MAX, 1'b0, 1'b1);
        random_traffic(150);

        start_phase(lsdc_pkg::TIMEOUT_RESET, 1'b1, 1'b1);
        random_traffic(150);

        start_phase(17'($urandom_range(1, 20)), 1'b1, 1'b1);
        random_traffic(160);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_door.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
